// ----- rtl/core/gspt_pkg.sv -----
// shared types, constants and fixed-point helpers for the grid snap point transform
// no dependencies; used by every module of the block
package gspt_pkg;

    localparam int W  = 40;
    localparam int F  = 24;
    localparam int W2 = 2 * W;
    localparam int HL = W / 2;
    localparam int HH = W - HL;
    localparam int MODE_W = 13;

    localparam int MB_RADIAL = 0;
    localparam int MB_NORM   = 1;
    localparam int MB_AXIS   = 2;
    localparam int MB_ROUND  = 5;
    localparam int MB_ROOT   = 8;
    localparam int MB_PLANE  = 9;
    localparam int MB_INV    = 12;

    localparam int MUL_LAT  = 2;
    localparam int SQRT_LAT = W;
    localparam int DIV_LAT  = W2;

    localparam int T_IN  = 1;
    localparam int T_SQ  = T_IN + MUL_LAT;
    localparam int T_M1  = T_SQ + 1;
    localparam int T_RT  = T_M1 + SQRT_LAT;
    localparam int T_M2  = T_RT + 1;
    localparam int T_D1  = T_M2 + DIV_LAT;
    localparam int T_Q   = T_D1 + 1;
    localparam int T_P1  = T_Q + MUL_LAT;
    localparam int T_D2  = T_P1 + DIV_LAT;
    localparam int T_A1  = T_D2 + 1;
    localparam int T_A2  = T_A1 + 1;
    localparam int T_A3  = T_A2 + 1;
    localparam int T_P2  = T_A3 + MUL_LAT;
    localparam int T_S2  = T_P2 + 1;
    localparam int T_P3  = T_S2 + MUL_LAT;
    localparam int T_OUT = T_P3 + 1;
    localparam int T_DE1 = T_IN + MUL_LAT + 1;
    localparam int T_DE2 = T_DE1 + MUL_LAT + 1;
    localparam int T_DE3 = T_DE2 + 1;

    localparam logic [W-1:0] MAXU = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE = W'(1) << F;

    typedef enum logic [2:0] {
        CFG_MODE, CFG_MASTER, CFG_MULT_X, CFG_MULT_Y,
        CFG_MULT_Z, CFG_POST, CFG_DE_SCALE, CFG_DE_OFFSET
    } cfg_idx_t;

    typedef struct packed {
        logic signed [W-1:0] pos_x;
        logic signed [W-1:0] pos_y;
        logic signed [W-1:0] pos_z;
        logic signed [W-1:0] dist_est;
    } in_t;

    typedef struct packed {
        logic signed [W-1:0] out_x;
        logic signed [W-1:0] out_y;
        logic signed [W-1:0] out_z;
        logic signed [W-1:0] out_dist_est;
        logic                div_fault;
    } out_t;

    typedef struct packed {
        logic                radial;
        logic                norm;
        logic                inv;
        logic                axis_en;
        logic                rnd;
        logic                cfg_fault;
        logic [W-1:0]        master;
        logic [W-1:0]        bs;
        logic signed [W-1:0] post;
    } lane_cfg_t;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
        return a[W-1] ? W'(-a) : W'(a);
    endfunction

    // floor of a signed quotient given its magnitude, saturated
    function automatic logic signed [W-1:0] fl_sat(input logic neg, input logic [W2-1:0] q,
                                                   input logic rnz);
        logic [W2:0] qq;
        logic [W2:0] lim;
        qq  = {1'b0, q} + (W2+1)'(neg & rnz);
        lim = (W2+1)'(MAXU) + (W2+1)'(neg);
        if (qq > lim) begin
            return neg ? MINV : MAXV;
        end
        return neg ? -$signed(qq[W-1:0]) : $signed(qq[W-1:0]);
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? MINV : MAXV;
        end
        return s[W-1:0];
    endfunction

    // nonnegative product shifted down by the fraction, saturated
    function automatic logic [W-1:0] sat_shr(input logic [W2-1:0] p);
        if (|p[W2-1:F+W-1]) begin
            return MAXU;
        end
        return W'(p[F+W-2:F]);
    endfunction

    function automatic logic [W-1:0] sadd_u(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W-1:0] s;
        s = a + b;
        return s[W-1] ? MAXU : s;
    endfunction

endpackage

// ----- rtl/core/gspt_mul.sv -----
// two-stage unsigned multiplier built from four half-width partial products
// depends on gspt_pkg
module gspt_mul (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [gspt_pkg::W-1:0]   a_i,
    input  logic [gspt_pkg::W-1:0]   b_i,
    output logic [gspt_pkg::W2-1:0]  p_o
);
    localparam int W  = gspt_pkg::W;
    localparam int W2 = gspt_pkg::W2;
    localparam int HL = gspt_pkg::HL;
    localparam int HH = gspt_pkg::HH;

    logic [2*HL-1:0]  ll_reg;
    logic [HL+HH-1:0] lh_reg;
    logic [HL+HH-1:0] hl_reg;
    logic [2*HH-1:0]  hh_reg;
    logic [W2-1:0]    p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= a_i[HL-1:0] * b_i[HL-1:0];
            lh_reg <= a_i[HL-1:0] * b_i[W-1:HL];
            hl_reg <= a_i[W-1:HL] * b_i[HL-1:0];
            hh_reg <= a_i[W-1:HL] * b_i[W-1:HL];
            p_reg  <= W2'(ll_reg) + (W2'(lh_reg) << HL) + (W2'(hl_reg) << HL)
                    + (W2'(hh_reg) << (2 * HL));
        end
    end

    assign p_o = p_reg;
endmodule

// ----- rtl/core/gspt_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on gspt_pkg
module gspt_div (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [gspt_pkg::W2-1:0]  n_i,
    input  logic [gspt_pkg::W-1:0]   d_i,
    output logic [gspt_pkg::W2-1:0]  q_o,
    output logic [gspt_pkg::W-1:0]   r_o
);
    localparam int W  = gspt_pkg::W;
    localparam int W2 = gspt_pkg::W2;

    logic [W-1:0]  rem_reg [W2];
    logic [W2-1:0] nq_reg  [W2];
    logic [W-1:0]  d_reg   [W2-1];

    for (genvar k = 0; k < W2; k++) begin : g_stage
        logic [W-1:0]  rp;
        logic [W2-1:0] np;
        logic [W-1:0]  dp;
        logic [W:0]    tr;
        logic          ge;
        if (k == 0) begin : g_first
            assign rp = '0;
            assign np = n_i;
            assign dp = d_i;
        end else begin : g_rest
            assign rp = rem_reg[k-1];
            assign np = nq_reg[k-1];
            assign dp = d_reg[k-1];
        end
        assign tr = {rp, np[W2-1]};
        assign ge = tr >= {1'b0, dp};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? W'(tr - {1'b0, dp}) : tr[W-1:0];
                nq_reg[k]  <= {np[W2-2:0], ge};
            end
        end
        if (k < W2 - 1) begin : g_d
            always_ff @(posedge aclk) begin
                if (en) begin
                    d_reg[k] <= dp;
                end
            end
        end
    end

    assign q_o = nq_reg[W2-1];
    assign r_o = rem_reg[W2-1];
endmodule

// ----- rtl/core/gspt_sqrt.sv -----
// pipelined digit-by-digit integer square root, one root bit per stage
// depends on gspt_pkg
module gspt_sqrt (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [gspt_pkg::W2-1:0]  x_i,
    output logic [gspt_pkg::W-1:0]   root_o
);
    localparam int W  = gspt_pkg::W;
    localparam int W2 = gspt_pkg::W2;

    logic [W+1:0]  rem_reg  [W];
    logic [W-1:0]  root_reg [W];
    logic [W2-1:0] x_reg    [W-1];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W+1:0]  rp;
        logic [W-1:0]  qp;
        logic [W2-1:0] xp;
        logic [W+3:0]  tr;
        logic [W+3:0]  trial;
        logic          ge;
        if (k == 0) begin : g_first
            assign rp = '0;
            assign qp = '0;
            assign xp = x_i;
        end else begin : g_rest
            assign rp = rem_reg[k-1];
            assign qp = root_reg[k-1];
            assign xp = x_reg[k-1];
        end
        assign tr    = {rp, xp[W2-1:W2-2]};
        assign trial = (W+4)'({qp, 2'b01});
        assign ge    = tr >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? (W+2)'(tr - trial) : tr[W+1:0];
                root_reg[k] <= {qp[W-2:0], ge};
            end
        end
        if (k < W - 1) begin : g_x
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[k] <= {xp[W2-3:0], 2'b00};
                end
            end
        end
    end

    assign root_o = root_reg[W-1];
endmodule

// ----- rtl/core/gspt_lane.sv -----
// one coordinate lane: square, first divide, scale, second divide, snap, length rescale, post-scale
// depends on gspt_pkg, gspt_mul, gspt_div
module gspt_lane (
    input  logic                          aclk,
    input  logic                          en,
    input  gspt_pkg::lane_cfg_t           cfg_i,
    input  logic signed [gspt_pkg::W-1:0] v_i,
    input  logic [gspt_pkg::W-1:0]        meas_i,
    output logic [gspt_pkg::W2-1:0]       sq_o,
    output logic signed [gspt_pkg::W-1:0] val_o,
    output logic                          fault_o
);
    localparam int W  = gspt_pkg::W;
    localparam int W2 = gspt_pkg::W2;
    localparam int F  = gspt_pkg::F;

    logic signed [W-1:0] car_reg [gspt_pkg::T_IN+1:gspt_pkg::T_OUT];
    logic [W-1:0]        md_reg  [gspt_pkg::T_M2+1:gspt_pkg::T_A3];
    logic [W-1:0]        den_reg [gspt_pkg::T_Q:gspt_pkg::T_P1];
    logic                fa_reg  [gspt_pkg::T_Q:gspt_pkg::T_OUT];
    logic [W-1:0]        num_reg;
    logic [W-1:0]        rr_reg;
    logic signed [W-1:0] base_reg;
    logic                cond_reg;

    logic [W2-1:0] d1_n, d2_n, q1, q2, p1, p2, p3;
    logic [W-1:0]  d1_d, d2_d, r1, r2, q_val, num_next, den_next, rr_next;
    logic signed [W-1:0] u_val, a1_val, snap_val, s2_val, out_val;
    logic fault_next;

    gspt_mul u_sq (.aclk, .en, .a_i(gspt_pkg::mag(v_i)), .b_i(gspt_pkg::mag(v_i)), .p_o(sq_o));

    gspt_div u_d1 (.aclk, .en, .n_i(d1_n), .d_i(d1_d), .q_o(q1), .r_o(r1));

    gspt_mul u_m1 (.aclk, .en, .a_i(gspt_pkg::mag(car_reg[gspt_pkg::T_Q])), .b_i(num_reg),
                   .p_o(p1));

    gspt_div u_d2 (.aclk, .en, .n_i(d2_n), .d_i(d2_d), .q_o(q2), .r_o(r2));

    gspt_mul u_m2 (.aclk, .en, .a_i(gspt_pkg::mag(car_reg[gspt_pkg::T_A3])),
                   .b_i(md_reg[gspt_pkg::T_A3]), .p_o(p2));

    gspt_mul u_m3 (.aclk, .en, .a_i(gspt_pkg::mag(car_reg[gspt_pkg::T_S2])),
                   .b_i(gspt_pkg::mag(cfg_i.post)), .p_o(p3));

    always_comb begin
        d1_n = cfg_i.radial ? W2'(meas_i) : (W2'(gspt_pkg::mag(car_reg[gspt_pkg::T_M2])) << F);
        d1_d = cfg_i.radial ? cfg_i.master : meas_i;

        q_val    = md_reg[gspt_pkg::T_D1] - r1;
        num_next = cfg_i.inv ? md_reg[gspt_pkg::T_D1] : q_val;
        den_next = cfg_i.inv ? q_val : md_reg[gspt_pkg::T_D1];
        u_val    = gspt_pkg::fl_sat(car_reg[gspt_pkg::T_D1][W-1], q1, |r1);
        if (cfg_i.radial) begin
            fault_next = cfg_i.cfg_fault || (den_next == '0);
        end else begin
            fault_next = cfg_i.cfg_fault || (cfg_i.norm && (md_reg[gspt_pkg::T_D1] == '0));
        end

        d2_n = cfg_i.radial ? p1 : W2'(gspt_pkg::mag(car_reg[gspt_pkg::T_P1]));
        d2_d = cfg_i.radial ? den_reg[gspt_pkg::T_P1] : cfg_i.bs;

        // floor modulo from the magnitude remainder
        rr_next = (car_reg[gspt_pkg::T_D2][W-1] && (|r2)) ? cfg_i.bs - r2 : r2;
        a1_val  = cfg_i.radial ? gspt_pkg::fl_sat(car_reg[gspt_pkg::T_D2][W-1], q2, |r2)
                               : car_reg[gspt_pkg::T_D2];

        if (cfg_i.rnd) begin
            snap_val = cond_reg ? gspt_pkg::sat_add(base_reg, $signed(cfg_i.bs)) : base_reg;
        end else begin
            snap_val = gspt_pkg::sat_add(base_reg, $signed(cfg_i.bs) >>> 1);
        end

        if (fa_reg[gspt_pkg::T_P2]) begin
            s2_val = '0;
        end else if (cfg_i.norm && !cfg_i.radial) begin
            s2_val = gspt_pkg::fl_sat(car_reg[gspt_pkg::T_P2][W-1], p2 >> F, |p2[F-1:0]);
        end else begin
            s2_val = car_reg[gspt_pkg::T_P2];
        end

        out_val = gspt_pkg::fl_sat(car_reg[gspt_pkg::T_P3][W-1] ^ cfg_i.post[W-1], p3 >> F,
                                   |p3[F-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            car_reg[gspt_pkg::T_IN+1] <= v_i;
            for (int t = gspt_pkg::T_IN + 2; t <= gspt_pkg::T_OUT; t++) begin
                if (t == gspt_pkg::T_Q) begin
                    car_reg[t] <= (cfg_i.norm && !cfg_i.radial) ? u_val
                                                                : car_reg[gspt_pkg::T_D1];
                end else if (t == gspt_pkg::T_A1) begin
                    car_reg[t] <= a1_val;
                end else if (t == gspt_pkg::T_A3) begin
                    car_reg[t] <= (!cfg_i.radial && cfg_i.axis_en) ? snap_val
                                                                   : car_reg[gspt_pkg::T_A2];
                end else if (t == gspt_pkg::T_S2) begin
                    car_reg[t] <= s2_val;
                end else if (t == gspt_pkg::T_OUT) begin
                    car_reg[t] <= out_val;
                end else begin
                    car_reg[t] <= car_reg[t-1];
                end
            end

            md_reg[gspt_pkg::T_M2+1] <= meas_i;
            for (int t = gspt_pkg::T_M2 + 2; t <= gspt_pkg::T_A3; t++) begin
                md_reg[t] <= md_reg[t-1];
            end

            den_reg[gspt_pkg::T_Q] <= den_next;
            for (int t = gspt_pkg::T_Q + 1; t <= gspt_pkg::T_P1; t++) begin
                den_reg[t] <= den_reg[t-1];
            end

            fa_reg[gspt_pkg::T_Q] <= fault_next;
            for (int t = gspt_pkg::T_Q + 1; t <= gspt_pkg::T_OUT; t++) begin
                fa_reg[t] <= fa_reg[t-1];
            end

            num_reg  <= num_next;
            rr_reg   <= rr_next;
            base_reg <= gspt_pkg::sat_add(car_reg[gspt_pkg::T_A1], -$signed(rr_reg));
            cond_reg <= rr_reg >= (cfg_i.bs - rr_reg);
        end
    end

    assign val_o   = car_reg[gspt_pkg::T_OUT];
    assign fault_o = fa_reg[gspt_pkg::T_OUT];
endmodule

// ----- rtl/core/grid_snap_point_transform.sv -----
// Grid snap point transform, top level: config registers, cell-size products, radial and
// length measure with its shared square root, three coordinate lanes and the estimate path.
// Depends on gspt_pkg, gspt_mul, gspt_sqrt, gspt_lane.
//
// One point is taken every cycle while the pipeline is not stalled. The path runs through the
// 40-step square root, the two 80-step divider chains in each lane and the multiplier and
// rounding stages around them. The pipeline advances as one: while a finished result is held
// with m_ready low, no new request is taken. Config writes are taken at any time and must
// only be made while no point is in flight.
module grid_snap_point_transform (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  gspt_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output gspt_pkg::out_t                m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [gspt_pkg::W-1:0]        cfg_data
);
    localparam int W  = gspt_pkg::W;
    localparam int W2 = gspt_pkg::W2;
    localparam int F  = gspt_pkg::F;

    logic [gspt_pkg::MODE_W-1:0] mode_reg;
    logic [W-1:0]                master_reg;
    logic [W-1:0]                mult_reg [3];
    logic signed [W-1:0]         post_reg, de_scale_reg, de_offset_reg;

    logic                        vld_reg [gspt_pkg::T_IN:gspt_pkg::T_OUT];
    gspt_pkg::in_t               in_reg;
    logic                        en;

    logic [W2-1:0]               bs_p [3];
    logic [W-1:0]                bs_reg [3];
    logic [W2-1:0]               sq [3];
    logic signed [W-1:0]         lane_v [3];
    logic signed [W-1:0]         lane_val [3];
    logic                        lane_fault [3];
    gspt_pkg::lane_cfg_t         lane_cfg [3];
    logic                        snap_fault;

    logic [W-1:0]                s0, s1, s2, m3, mpre_next;
    logic [W2-1:0]               sqin_reg;
    logic [W-1:0]                mpre_d [gspt_pkg::T_M1:gspt_pkg::T_RT];
    logic                        root_d [gspt_pkg::T_M1:gspt_pkg::T_RT];
    logic [W-1:0]                root, root_c, meas_reg;

    logic [W2-1:0]               de_p1, de_p2;
    logic                        dneg1_reg [gspt_pkg::T_IN+1:gspt_pkg::T_DE1-1];
    logic                        dneg2_reg [gspt_pkg::T_DE1+1:gspt_pkg::T_DE2-1];
    logic signed [W-1:0]         de1_reg, de2_reg;
    logic signed [W-1:0]         de_d [gspt_pkg::T_DE3:gspt_pkg::T_OUT];

    assign en        = !vld_reg[gspt_pkg::T_OUT] || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // configuration registers and request valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= gspt_pkg::MODE_W'(28);
            master_reg    <= gspt_pkg::ONE;
            mult_reg[0]   <= gspt_pkg::ONE;
            mult_reg[1]   <= gspt_pkg::ONE;
            mult_reg[2]   <= gspt_pkg::ONE;
            post_reg      <= $signed(gspt_pkg::ONE);
            de_scale_reg  <= $signed(gspt_pkg::ONE);
            de_offset_reg <= '0;
            for (int t = gspt_pkg::T_IN; t <= gspt_pkg::T_OUT; t++) begin
                vld_reg[t] <= 1'b0;
            end
        end else begin
            if (cfg_valid) begin
                case (gspt_pkg::cfg_idx_t'(cfg_index))
                    gspt_pkg::CFG_MODE:      mode_reg      <= cfg_data[gspt_pkg::MODE_W-1:0];
                    gspt_pkg::CFG_MASTER:    master_reg    <= {1'b0, cfg_data[W-2:0]};
                    gspt_pkg::CFG_MULT_X:    mult_reg[0]   <= {1'b0, cfg_data[W-2:0]};
                    gspt_pkg::CFG_MULT_Y:    mult_reg[1]   <= {1'b0, cfg_data[W-2:0]};
                    gspt_pkg::CFG_MULT_Z:    mult_reg[2]   <= {1'b0, cfg_data[W-2:0]};
                    gspt_pkg::CFG_POST:      post_reg      <= $signed(cfg_data);
                    gspt_pkg::CFG_DE_SCALE:  de_scale_reg  <= $signed(cfg_data);
                    gspt_pkg::CFG_DE_OFFSET: de_offset_reg <= $signed(cfg_data);
                    default: begin
                    end
                endcase
            end
            if (en) begin
                vld_reg[gspt_pkg::T_IN] <= s_valid;
                for (int t = gspt_pkg::T_IN + 1; t <= gspt_pkg::T_OUT; t++) begin
                    vld_reg[t] <= vld_reg[t-1];
                end
            end
        end
    end

    // cell sizes follow the registers after a write, through the multiplier stages and bs_reg
    for (genvar i = 0; i < 3; i++) begin : g_bs
        gspt_mul u_bs (.aclk, .en, .a_i(mult_reg[i]), .b_i(master_reg), .p_o(bs_p[i]));
        always_ff @(posedge aclk) begin
            if (en) begin
                bs_reg[i] <= gspt_pkg::sat_shr(bs_p[i]);
            end
        end
    end

    assign snap_fault = (mode_reg[gspt_pkg::MB_AXIS]   && (bs_reg[0] == '0))
                     || (mode_reg[gspt_pkg::MB_AXIS+1] && (bs_reg[1] == '0))
                     || (mode_reg[gspt_pkg::MB_AXIS+2] && (bs_reg[2] == '0));

    assign lane_v[0] = in_reg.pos_x;
    assign lane_v[1] = in_reg.pos_y;
    assign lane_v[2] = in_reg.pos_z;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        always_comb begin
            lane_cfg[i].radial    = mode_reg[gspt_pkg::MB_RADIAL];
            lane_cfg[i].norm      = mode_reg[gspt_pkg::MB_NORM];
            lane_cfg[i].inv       = mode_reg[gspt_pkg::MB_INV];
            lane_cfg[i].axis_en   = mode_reg[gspt_pkg::MB_AXIS+i];
            lane_cfg[i].rnd       = mode_reg[gspt_pkg::MB_ROUND+i];
            lane_cfg[i].cfg_fault = mode_reg[gspt_pkg::MB_RADIAL] ? (master_reg == '0)
                                                                  : snap_fault;
            lane_cfg[i].master    = master_reg;
            lane_cfg[i].bs        = bs_reg[i];
            lane_cfg[i].post      = post_reg;
        end
        gspt_lane u_lane (
            .aclk, .en, .cfg_i(lane_cfg[i]), .v_i(lane_v[i]), .meas_i(meas_reg),
            .sq_o(sq[i]), .val_o(lane_val[i]), .fault_o(lane_fault[i])
        );
    end

    // merge of the squares into the radial measure or the exact length input
    always_comb begin
        s0 = gspt_pkg::sat_shr(sq[0]);
        s1 = gspt_pkg::sat_shr(sq[1]);
        s2 = gspt_pkg::sat_shr(sq[2]);
        m3 = gspt_pkg::sadd_u(gspt_pkg::sadd_u(s0, s1), s2);
        if (mode_reg[gspt_pkg::MB_PLANE+2]) begin
            mpre_next = gspt_pkg::sadd_u(s2, s0);
        end else if (mode_reg[gspt_pkg::MB_PLANE+1]) begin
            mpre_next = gspt_pkg::sadd_u(s1, s2);
        end else if (mode_reg[gspt_pkg::MB_PLANE]) begin
            mpre_next = gspt_pkg::sadd_u(s0, s1);
        end else begin
            mpre_next = m3;
        end
        root_c = root[W-1] ? gspt_pkg::MAXU : root;
    end

    gspt_sqrt u_sqrt (.aclk, .en, .x_i(sqin_reg), .root_o(root));

    gspt_mul u_de1 (.aclk, .en, .a_i(gspt_pkg::mag(in_reg.dist_est)),
                    .b_i(gspt_pkg::mag(post_reg)), .p_o(de_p1));
    gspt_mul u_de2 (.aclk, .en, .a_i(gspt_pkg::mag(de1_reg)),
                    .b_i(gspt_pkg::mag(de_scale_reg)), .p_o(de_p2));

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= s_data;

            sqin_reg <= mode_reg[gspt_pkg::MB_RADIAL] ? (W2'(m3) << F) : sq[0] + sq[1] + sq[2];
            mpre_d[gspt_pkg::T_M1] <= mpre_next;
            root_d[gspt_pkg::T_M1] <= mode_reg[gspt_pkg::MB_ROOT]
                                   && !(|mode_reg[gspt_pkg::MB_PLANE+2:gspt_pkg::MB_PLANE]);
            for (int t = gspt_pkg::T_M1 + 1; t <= gspt_pkg::T_RT; t++) begin
                mpre_d[t] <= mpre_d[t-1];
                root_d[t] <= root_d[t-1];
            end
            if (mode_reg[gspt_pkg::MB_RADIAL]) begin
                meas_reg <= root_d[gspt_pkg::T_RT] ? root_c : mpre_d[gspt_pkg::T_RT];
            end else begin
                meas_reg <= root_c;
            end

            dneg1_reg[gspt_pkg::T_IN+1] <= in_reg.dist_est[W-1] ^ post_reg[W-1];
            for (int t = gspt_pkg::T_IN + 2; t < gspt_pkg::T_DE1; t++) begin
                dneg1_reg[t] <= dneg1_reg[t-1];
            end
            de1_reg <= gspt_pkg::fl_sat(dneg1_reg[gspt_pkg::T_DE1-1], de_p1 >> F,
                                        |de_p1[F-1:0]);
            dneg2_reg[gspt_pkg::T_DE1+1] <= de1_reg[W-1] ^ de_scale_reg[W-1];
            for (int t = gspt_pkg::T_DE1 + 2; t < gspt_pkg::T_DE2; t++) begin
                dneg2_reg[t] <= dneg2_reg[t-1];
            end
            de2_reg <= gspt_pkg::fl_sat(dneg2_reg[gspt_pkg::T_DE2-1], de_p2 >> F,
                                        |de_p2[F-1:0]);
            de_d[gspt_pkg::T_DE3] <= gspt_pkg::sat_add(de2_reg, de_offset_reg);
            for (int t = gspt_pkg::T_DE3 + 1; t <= gspt_pkg::T_OUT; t++) begin
                de_d[t] <= de_d[t-1];
            end
        end
    end

    assign m_valid             = vld_reg[gspt_pkg::T_OUT];
    assign m_data.out_x        = lane_val[0];
    assign m_data.out_y        = lane_val[1];
    assign m_data.out_z        = lane_val[2];
    assign m_data.out_dist_est = de_d[gspt_pkg::T_OUT];
    assign m_data.div_fault    = lane_fault[0] | lane_fault[1] | lane_fault[2];
endmodule

// ----- dv/tb.sv -----
// testbench for grid_snap_point_transform: directed and random points checked against an
// in-bench fixed-point predictor, with random stalls on both channels
// depends on gspt_pkg and the rtl top level
`timescale 1ns / 1ps

module tb;
    localparam int W      = gspt_pkg::W;
    localparam int F      = gspt_pkg::F;
    localparam int MODE_W = gspt_pkg::MODE_W;

    localparam longint Q_MAX = (64'sd1 <<< (W - 1)) - 1;
    localparam longint Q_MIN = -Q_MAX - 1;
    localparam longint FX1   = 64'sd1 <<< F;
    localparam longint UMASK = Q_MAX;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    gspt_pkg::in_t  s_data;
    logic m_valid;
    logic m_ready;
    gspt_pkg::out_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [W-1:0] cfg_data;

    grid_snap_point_transform uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // predictor copy of the register file
    logic [MODE_W-1:0] mode_q;
    longint master_q;
    longint mult_q [3];
    longint post_q;
    longint de_scale_q;
    longint de_off_q;

    gspt_pkg::out_t expected_points [$];
    int     errors;
    bit     steady;
    int     ready_hold;

    function automatic logic [63:0] q_mag(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint q_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > Q_MAX) return Q_MAX;
        if (s < Q_MIN) return Q_MIN;
        return s;
    endfunction

    // floor(a * b / d), saturated
    function automatic longint q_muldiv(longint a, longint b, logic [63:0] d);
        logic [127:0] p, qt, rm;
        logic neg;
        neg = (a < 0) != (b < 0);
        p   = {64'd0, q_mag(a)} * {64'd0, q_mag(b)};
        qt  = p / {64'd0, d};
        rm  = p % {64'd0, d};
        if (neg && rm != 0) qt = qt + 1;
        if (neg) begin
            if (qt > 128'(Q_MAX) + 1) return Q_MIN;
            return -longint'(qt[63:0]);
        end
        if (qt > 128'(Q_MAX)) return Q_MAX;
        return longint'(qt[63:0]);
    endfunction

    function automatic logic [63:0] q_isqrt(logic [127:0] x);
        logic [63:0] res, c;
        res = 0;
        for (int b = 63; b >= 0; b--) begin
            c = res | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= x) res = c;
        end
        return res;
    endfunction

    function automatic longint cell_snap(longint v, longint b, bit rnd);
        longint r, base;
        r = v % b;
        if (r < 0) r += b;
        base = q_add(v, -r);
        if (!rnd) return q_add(base, b >>> 1);
        if (r >= b - r) base = q_add(base, b);
        return base;
    endfunction

    function automatic bit snap_axes(inout longint v[3]);
        longint bs [3];
        for (int i = 0; i < 3; i++) begin
            bs[i] = q_muldiv(mult_q[i], master_q, FX1);
            if (mode_q[gspt_pkg::MB_AXIS+i] && bs[i] <= 0) return 1'b1;
        end
        for (int i = 0; i < 3; i++)
            if (mode_q[gspt_pkg::MB_AXIS+i])
                v[i] = cell_snap(v[i], bs[i], mode_q[gspt_pkg::MB_ROUND+i]);
        return 1'b0;
    endfunction

    function automatic gspt_pkg::out_t predict_snap(gspt_pkg::in_t p);
        longint v [3];
        longint u [3];
        longint sq [3];
        longint de, m, q, num, den, len;
        logic [127:0] acc;
        bit fault;
        gspt_pkg::out_t o;
        v[0] = longint'(p.pos_x);
        v[1] = longint'(p.pos_y);
        v[2] = longint'(p.pos_z);
        de = longint'(p.dist_est);
        fault = 1'b0;
        if (mode_q[gspt_pkg::MB_RADIAL]) begin
            for (int i = 0; i < 3; i++) sq[i] = q_muldiv(v[i], v[i], FX1);
            m = q_add(q_add(sq[0], sq[1]), sq[2]);
            if (mode_q[gspt_pkg::MB_ROOT]) begin
                acc = q_isqrt({64'd0, 64'(m)} << F);
                m = acc > 128'(Q_MAX) ? Q_MAX : longint'(acc[63:0]);
            end
            if (mode_q[gspt_pkg::MB_PLANE])   m = q_add(sq[0], sq[1]);
            if (mode_q[gspt_pkg::MB_PLANE+1]) m = q_add(sq[1], sq[2]);
            if (mode_q[gspt_pkg::MB_PLANE+2]) m = q_add(sq[2], sq[0]);
            if (master_q <= 0) fault = 1'b1;
            else begin
                q = m - m % master_q;
                num = mode_q[gspt_pkg::MB_INV] ? m : q;
                den = mode_q[gspt_pkg::MB_INV] ? q : m;
                if (den == 0) fault = 1'b1;
                else for (int i = 0; i < 3; i++) v[i] = q_muldiv(v[i], num, 64'(den));
            end
        end else if (mode_q[gspt_pkg::MB_NORM]) begin
            acc = 0;
            for (int i = 0; i < 3; i++) acc += {64'd0, q_mag(v[i])} * {64'd0, q_mag(v[i])};
            acc = q_isqrt(acc);
            len = acc > 128'(Q_MAX) ? Q_MAX : longint'(acc[63:0]);
            if (len == 0) fault = 1'b1;
            else begin
                for (int i = 0; i < 3; i++) u[i] = q_muldiv(v[i], FX1, 64'(len));
                fault = snap_axes(u);
                if (!fault) for (int i = 0; i < 3; i++) v[i] = q_muldiv(u[i], len, FX1);
            end
        end else begin
            fault = snap_axes(v);
        end
        for (int i = 0; i < 3; i++) begin
            if (fault) v[i] = 0;
            v[i] = q_muldiv(v[i], post_q, FX1);
        end
        de = q_muldiv(de, post_q, FX1);
        de = q_muldiv(de, de_scale_q, FX1);
        de = q_add(de, de_off_q);
        o.out_x = v[0][W-1:0];
        o.out_y = v[1][W-1:0];
        o.out_z = v[2][W-1:0];
        o.out_dist_est = de[W-1:0];
        o.div_fault = fault;
        return o;
    endfunction

    function automatic int rand_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint rand40();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return longint'($signed(r[W-1:0]));
    endfunction

    function automatic longint rand_coord();
        case ($urandom_range(0, 5))
            0: return rand40();
            1: begin
                case ($urandom_range(0, 6))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 0;
                    3: return FX1;
                    4: return -FX1;
                    5: return 1;
                    default: return -1;
                endcase
            end
            default: return rand40() >>> $urandom_range(6, 20);
        endcase
    endfunction

    function automatic longint rand_size();
        case ($urandom_range(0, 5))
            0: return FX1;
            1: return rand40() & UMASK;
            2: return longint'($urandom_range(1, 255));
            default: return longint'($urandom_range(1 << 14, 1 << 28));
        endcase
    endfunction

    function automatic longint rand_scale();
        case ($urandom_range(0, 5))
            0: return FX1;
            1: return -FX1;
            2: return rand40();
            default: return rand40() >>> $urandom_range(12, 16);
        endcase
    endfunction

    // result checker and ready stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", m_data);
                end else begin
                    gspt_pkg::out_t e;
                    e = expected_points.pop_front();
                    if (m_data.out_x !== e.out_x || m_data.out_y !== e.out_y ||
                        m_data.out_z !== e.out_z || m_data.out_dist_est !== e.out_dist_est ||
                        m_data.div_fault !== e.div_fault) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected x=%h y=%h z=%h de=%h f=%b ",
                                      "actual x=%h y=%h z=%h de=%h f=%b"},
                                     e.out_x, e.out_y, e.out_z, e.out_dist_est, e.div_fault,
                                     m_data.out_x, m_data.out_y, m_data.out_z,
                                     m_data.out_dist_est, m_data.div_fault);
                    end
                end
            end
            if (steady) begin
                m_ready <= 1'b1;
            end else if (ready_hold != 0) begin
                ready_hold <= ready_hold - 1;
            end else begin
                m_ready <= ($urandom_range(0, 2) != 0);
                ready_hold <= rand_gap();
            end
        end
    end

    task automatic send_point(longint x, longint y, longint z, longint d);
        int gap;
        gspt_pkg::in_t p;
        gap = rand_gap();
        p.pos_x = x[W-1:0];
        p.pos_y = y[W-1:0];
        p.pos_z = z[W-1:0];
        p.dist_est = d[W-1:0];
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= p;
        do @(posedge aclk); while (!s_ready);
        expected_points.push_back(predict_snap(p));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(gspt_pkg::cfg_idx_t idx, longint val);
        logic [63:0] raw;
        raw = 64'(val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= raw[W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            gspt_pkg::CFG_MODE:      mode_q = raw[MODE_W-1:0];
            gspt_pkg::CFG_MASTER:    master_q = longint'(raw[W-2:0]);
            gspt_pkg::CFG_MULT_X:    mult_q[0] = longint'(raw[W-2:0]);
            gspt_pkg::CFG_MULT_Y:    mult_q[1] = longint'(raw[W-2:0]);
            gspt_pkg::CFG_MULT_Z:    mult_q[2] = longint'(raw[W-2:0]);
            gspt_pkg::CFG_POST:      post_q = longint'($signed(raw[W-1:0]));
            gspt_pkg::CFG_DE_SCALE:  de_scale_q = longint'($signed(raw[W-1:0]));
            gspt_pkg::CFG_DE_OFFSET: de_off_q = longint'($signed(raw[W-1:0]));
            default: ;
        endcase
    endtask

    task automatic test_defaults();
        send_point(0, 0, 0, 0);
        send_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_point(FX1 * 3 / 2, -FX1 * 3 / 2, FX1 / 2 - 1, 12345);
        send_point(-1, 1, Q_MIN + 1, -FX1);
        drain();
    endtask

    task automatic test_cartesian();
        write_reg(gspt_pkg::CFG_MODE, 28 | 224);
        write_reg(gspt_pkg::CFG_MASTER, FX1 / 4);
        write_reg(gspt_pkg::CFG_MULT_X, FX1 * 2);
        write_reg(gspt_pkg::CFG_MULT_Y, FX1 / 2);
        write_reg(gspt_pkg::CFG_MULT_Z, FX1 * 3);
        send_point(FX1 / 4, -FX1 / 4, FX1 * 3 / 8, FX1);
        send_point(Q_MAX, Q_MIN, -FX1 * 5, -FX1);
        drain();
        write_reg(gspt_pkg::CFG_POST, -FX1 * 2);
        write_reg(gspt_pkg::CFG_DE_SCALE, FX1 / 2);
        write_reg(gspt_pkg::CFG_DE_OFFSET, Q_MIN);
        write_reg(gspt_pkg::CFG_MODE, 4 | 32);
        send_point(FX1 * 7 / 16, FX1 * 7 / 16, FX1 * 7 / 16, Q_MAX);
        drain();
    endtask

    task automatic test_normalized();
        write_reg(gspt_pkg::CFG_POST, FX1);
        write_reg(gspt_pkg::CFG_DE_SCALE, FX1);
        write_reg(gspt_pkg::CFG_DE_OFFSET, FX1);
        write_reg(gspt_pkg::CFG_MODE, 2 | 28 | 64);
        send_point(0, 0, 0, FX1);
        send_point(FX1 * 3, FX1 * 4, 0, FX1);
        send_point(-FX1, FX1 / 3, Q_MAX, 0);
        drain();
    endtask

    task automatic test_radial();
        logic [MODE_W-1:0] modes [6];
        modes = '{1, 1 | 256, 1 | 512, 1 | 1024, 1 | 2048, 1 | 4096 | 256};
        write_reg(gspt_pkg::CFG_MASTER, FX1 / 2);
        foreach (modes[i]) begin
            write_reg(gspt_pkg::CFG_MODE, modes[i]);
            send_point(FX1 * 3 / 2, -FX1, FX1 / 3, FX1);
            if (i == 0 || i == 5) send_point(0, 0, 0, FX1);
            drain();
        end
        write_reg(gspt_pkg::CFG_MODE, 1 | 4096);
        send_point(FX1 / 8, 0, 0, 0);
        drain();
    endtask

    task automatic test_faults();
        write_reg(gspt_pkg::CFG_MODE, 28);
        write_reg(gspt_pkg::CFG_MASTER, 0);
        send_point(FX1, FX1, FX1, FX1);
        drain();
        write_reg(gspt_pkg::CFG_MODE, 1);
        send_point(FX1, FX1, FX1, FX1);
        drain();
        write_reg(gspt_pkg::CFG_MASTER, Q_MAX);
        write_reg(gspt_pkg::CFG_MULT_X, Q_MAX);
        write_reg(gspt_pkg::CFG_MULT_Y, 1);
        write_reg(gspt_pkg::CFG_MODE, 28);
        write_reg(gspt_pkg::CFG_POST, Q_MAX);
        write_reg(gspt_pkg::CFG_DE_SCALE, Q_MIN);
        write_reg(gspt_pkg::CFG_DE_OFFSET, Q_MAX);
        send_point(FX1, -FX1, 5, -5);
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 15; ph++) begin
            write_reg(gspt_pkg::CFG_MODE,
                      ph == 0 ? 0 : (ph == 1 ? 8191 : $urandom_range(0, 8191)));
            write_reg(gspt_pkg::CFG_MASTER, rand_size());
            write_reg(gspt_pkg::CFG_MULT_X, rand_size());
            write_reg(gspt_pkg::CFG_MULT_Y, rand_size());
            write_reg(gspt_pkg::CFG_MULT_Z, rand_size());
            write_reg(gspt_pkg::CFG_POST, rand_scale());
            write_reg(gspt_pkg::CFG_DE_SCALE, rand_scale());
            write_reg(gspt_pkg::CFG_DE_OFFSET, rand_scale());
            steady = (ph % 5 == 2);
            for (int n = 0; n < 50; n++) begin
                if (n == 25 && ph % 3 == 0) begin
                    drain();
                end
                send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= gspt_pkg::CFG_MODE;
        cfg_data <= '0;
        errors = 0;
        steady = 1'b0;
        mode_q = 28;
        master_q = FX1;
        mult_q = '{FX1, FX1, FX1};
        post_q = FX1;
        de_scale_q = FX1;
        de_off_q = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_cartesian();
        test_normalized();
        test_radial();
        test_faults();
        test_random();
        drain();
        repeat (230) @(posedge aclk);
        if (expected_points.size() != 0) errors++;
        if (errors == 0) begin
            $display("PASS grid_snap_point_transform");
        end else begin
            $display("FAIL grid_snap_point_transform");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("FAIL grid_snap_point_transform");
        $finish;
    end

endmodule
